>>> rtl/mnr_pkg.sv
`timescale 1ns / 1ps

package mnr_pkg;

	localparam int HELD_DEPTH_DEF = 16;
	localparam int NUM_RES        = 6;
	localparam int RES_IW         = $clog2(NUM_RES);

	localparam logic [7:0] NONE_NOTE  = 8'hFF;
	localparam logic [6:0] RETRIG_VEL = 7'd108;

	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;

	localparam logic [1:0] MODE_POLY   = 2'd0;
	localparam logic [1:0] MODE_LEGATO = 2'd1;
	localparam logic [1:0] MODE_RETRIG = 2'd2;

	localparam logic [1:0] CFG_CHORD_ENABLE = 2'd0;
	localparam logic [1:0] CFG_CHORD_MINOR  = 2'd1;
	localparam logic [1:0] CFG_PLAY_MODE    = 2'd2;

	typedef struct packed {
		logic [7:0]  status_byte;
		logic [6:0]  data_one;
		logic [6:0]  data_two;
		logic [15:0] event_offset;
	} in_item_t;

	typedef struct packed {
		logic        midi_valid;
		logic [7:0]  out_status;
		logic [6:0]  out_data_one;
		logic [6:0]  out_data_two;
		logic [15:0] out_offset;
		logic        glide_valid;
		logic [6:0]  glide_note;
		logic        glide_instant;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic clear;
		logic remove;
		logic push;
	} stack_ctl_t;

	typedef struct packed {
		logic       empty;
		logic [6:0] top;
	} stack_sts_t;

	// chord intervals relative to the root, in semitones
	function automatic logic signed [8:0] chord_ofs(input logic [RES_IW-1:0] idx,
		input logic minor);
		logic signed [8:0] ofs;
		case (idx)
			3'd0: ofs = -9'sd12;
			3'd1: ofs = 9'sd0;
			3'd2: ofs = 9'sd7;
			3'd3: ofs = minor ? 9'sd15 : 9'sd16;
			3'd4: ofs = 9'sd19;
			3'd5: ofs = minor ? 9'sd34 : 9'sd35;
			default: ofs = 9'sd0;
		endcase
		return ofs;
	endfunction

endpackage

>>> rtl/midi_note_router_chord_mono.sv
`timescale 1ns / 1ps

// The first result is registered on rsp after the item has passed the REMOVE, PUSH, PLAN and EMIT states.
// A new item is taken only back in IDLE, once the last result is loaded; the sequencer walks
// the six-slot buffer one slot a cycle while rsp_stall does not hold the output register.
// The held-note stack is a row of cells with the newest note in cell 0.
// Reset: config registers zero, stack empty, started and sounding notes none;
// no clearing pass, the block takes an item right after reset.
module midi_note_router_chord_mono #(
	parameter int HELD_DEPTH = mnr_pkg::HELD_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  mnr_pkg::in_item_t  req_item,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output mnr_pkg::out_item_t rsp_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REMOVE = 5'b00010,
		ST_PUSH   = 5'b00100,
		ST_PLAN   = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t                         state_q;
	logic                           chord_enable_q;
	logic                           chord_minor_q;
	logic [1:0]                     play_mode_q;
	mnr_pkg::in_item_t              item_q;
	logic                           on_q;
	logic                           off_q;
	logic [1:0]                     mode_q;
	logic [7:0]                     started_q;
	logic [7:0]                     sounding_q;
	mnr_pkg::out_item_t             res_q [mnr_pkg::NUM_RES];
	logic [mnr_pkg::NUM_RES-1:0]    res_vld_q;
	logic [mnr_pkg::RES_IW-1:0]     k_q;
	mnr_pkg::out_item_t             out_q;
	logic                           out_valid_q;

	logic                           accept;
	logic [3:0]                     hi;
	logic                           dec_on;
	logic                           dec_off;
	logic                           mono_q;
	mnr_pkg::stack_ctl_t            ctl;
	mnr_pkg::stack_sts_t            sts;
	mnr_pkg::out_item_t             plan_res [mnr_pkg::NUM_RES];
	logic [mnr_pkg::NUM_RES-1:0]    plan_vld;
	logic [7:0]                     plan_started;
	logic [7:0]                     plan_sounding;
	logic                           plan_clear;
	logic                           can_load;
	logic                           load;
	logic                           last_k;
	mnr_pkg::out_item_t             emit_res;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign hi      = req_item.status_byte[7:4];
	assign dec_on  = (hi == mnr_pkg::NIB_NOTE_ON) && (req_item.data_two != 7'd0);
	assign dec_off = (hi == mnr_pkg::NIB_NOTE_OFF)
		|| ((hi == mnr_pkg::NIB_NOTE_ON) && (req_item.data_two == 7'd0));
	assign mono_q  = (mode_q == mnr_pkg::MODE_LEGATO) || (mode_q == mnr_pkg::MODE_RETRIG);

	assign ctl.remove = (state_q == ST_REMOVE) && mono_q && (on_q || off_q);
	assign ctl.push   = (state_q == ST_PUSH) && mono_q && on_q;
	assign ctl.clear  = (state_q == ST_PLAN) && plan_clear;

	mnr_stack #(
		.DEPTH (HELD_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.key    (item_q.data_one),
		.sts    (sts)
	);

	mnr_plan u_plan (
		.item         (item_q),
		.is_on        (on_q),
		.is_off       (off_q),
		.mode         (mode_q),
		.chord_enable (chord_enable_q),
		.chord_minor  (chord_minor_q),
		.started      (started_q),
		.sounding     (sounding_q),
		.sts          (sts),
		.res          (plan_res),
		.vld          (plan_vld),
		.nxt_started  (plan_started),
		.nxt_sounding (plan_sounding),
		.clear        (plan_clear)
	);

	// a slot is last when no later slot holds a result
	always_comb begin
		last_k = 1'b1;
		for (int i = 0; i < mnr_pkg::NUM_RES; i++) begin
			if (res_vld_q[i] && (mnr_pkg::RES_IW'(i) > k_q)) begin
				last_k = 1'b0;
			end
		end
	end

	always_comb begin
		emit_res             = res_q[k_q];
		emit_res.last_of_run = last_k;
	end

	assign can_load = !out_valid_q || !rsp_stall;
	assign load     = (state_q == ST_EMIT) && can_load && res_vld_q[k_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_enable_q <= 1'b0;
			chord_minor_q  <= 1'b0;
			play_mode_q    <= mnr_pkg::MODE_POLY;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mnr_pkg::CFG_CHORD_ENABLE: chord_enable_q <= cfg_data[0];
				mnr_pkg::CFG_CHORD_MINOR:  chord_minor_q  <= cfg_data[0];
				mnr_pkg::CFG_PLAY_MODE:    play_mode_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			started_q  <= mnr_pkg::NONE_NOTE;
			sounding_q <= mnr_pkg::NONE_NOTE;
			res_vld_q  <= '0;
			k_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_REMOVE;
					end
				end
				ST_REMOVE: state_q <= ST_PUSH;
				ST_PUSH:   state_q <= ST_PLAN;
				ST_PLAN: begin
					started_q  <= plan_started;
					sounding_q <= plan_sounding;
					res_vld_q  <= plan_vld;
					k_q        <= '0;
					state_q    <= (plan_vld != '0) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (can_load) begin
						if (res_vld_q[k_q] && last_k) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + mnr_pkg::RES_IW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_item;
			on_q   <= dec_on;
			off_q  <= dec_off;
			mode_q <= chord_enable_q ? mnr_pkg::MODE_POLY : play_mode_q;
		end
		if (state_q == ST_PLAN) begin
			res_q <= plan_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= emit_res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_item  = out_q;

endmodule

>>> rtl/mnr_cell.sv
`timescale 1ns / 1ps

module mnr_cell (
	input  logic                clk,
	input  mnr_pkg::stack_ctl_t ctl,
	input  logic                occ,
	input  logic [6:0]          key,
	input  logic [6:0]          newer,
	input  logic [6:0]          older,
	input  logic                seen_in,
	output logic                seen_out,
	output logic [6:0]          note
);

	logic [6:0] note_q;
	logic       hit;

	assign hit      = occ && (note_q == key);
	assign seen_out = seen_in | hit;
	assign note     = note_q;

	// push shifts toward the old end; removal closes the gap from the old end
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			note_q <= newer;
		end else if (ctl.remove && seen_out) begin
			note_q <= older;
		end
	end

endmodule

>>> rtl/mnr_stack.sv
`timescale 1ns / 1ps

module mnr_stack #(
	parameter int DEPTH = mnr_pkg::HELD_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mnr_pkg::stack_ctl_t ctl,
	input  logic [6:0]          key,
	output mnr_pkg::stack_sts_t sts
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [6:0]    notes [DEPTH];
	logic          seen  [DEPTH+1];

	assign seen[0] = 1'b0;

	// cell 0 holds the newest note
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [6:0] newer_n;
		logic [6:0] older_n;
		if (j == 0) begin : g_first
			assign newer_n = key;
		end else begin : g_mid
			assign newer_n = notes[j-1];
		end
		if (j == DEPTH - 1) begin : g_last
			assign older_n = notes[j];
		end else begin : g_inner
			assign older_n = notes[j+1];
		end
		mnr_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.occ      (CW'(j) < count_q),
			.key      (key),
			.newer    (newer_n),
			.older    (older_n),
			.seen_in  (seen[j]),
			.seen_out (seen[j+1]),
			.note     (notes[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.remove && seen[DEPTH]) begin
			count_q <= count_q - CW'(1);
		end else if (ctl.push && (count_q != CW'(DEPTH))) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign sts.empty = (count_q == '0);
	assign sts.top   = notes[0];

endmodule

>>> rtl/mnr_plan.sv
`timescale 1ns / 1ps

module mnr_plan (
	input  mnr_pkg::in_item_t   item,
	input  logic                is_on,
	input  logic                is_off,
	input  logic [1:0]          mode,
	input  logic                chord_enable,
	input  logic                chord_minor,
	input  logic [7:0]          started,
	input  logic [7:0]          sounding,
	input  mnr_pkg::stack_sts_t sts,
	output mnr_pkg::out_item_t  res [mnr_pkg::NUM_RES],
	output logic [mnr_pkg::NUM_RES-1:0] vld,
	output logic [7:0]          nxt_started,
	output logic [7:0]          nxt_sounding,
	output logic                clear
);

	logic signed [8:0]   chord_n [mnr_pkg::NUM_RES];
	logic                note_ev;
	logic                mono;
	logic [3:0]          ch;
	logic [7:0]          key8;
	mnr_pkg::out_item_t  pass;

	assign note_ev = is_on || is_off;
	assign mono    = (mode == mnr_pkg::MODE_LEGATO) || (mode == mnr_pkg::MODE_RETRIG);
	assign ch      = item.status_byte[3:0];
	assign key8    = {1'b0, item.data_one};

	always_comb begin
		for (int i = 0; i < mnr_pkg::NUM_RES; i++) begin
			chord_n[i] = $signed({2'b00, item.data_one})
				+ mnr_pkg::chord_ofs(mnr_pkg::RES_IW'(i), chord_minor);
		end
	end

	always_comb begin
		pass               = '0;
		pass.midi_valid    = 1'b1;
		pass.out_status    = item.status_byte;
		pass.out_data_one  = item.data_one;
		pass.out_data_two  = item.data_two;
		pass.out_offset    = item.event_offset;
	end

	always_comb begin
		for (int i = 0; i < mnr_pkg::NUM_RES; i++) begin
			res[i]            = '0;
			res[i].out_offset = item.event_offset;
		end
		vld          = '0;
		nxt_started  = started;
		nxt_sounding = sounding;
		clear        = 1'b0;

		if (!mono) begin
			clear        = 1'b1;
			nxt_started  = mnr_pkg::NONE_NOTE;
			nxt_sounding = mnr_pkg::NONE_NOTE;
			if (chord_enable && note_ev) begin
				for (int i = 0; i < mnr_pkg::NUM_RES; i++) begin
					vld[i]              = (chord_n[i][8:7] == 2'b00);
					res[i].midi_valid   = 1'b1;
					res[i].out_status   = {is_on ? mnr_pkg::NIB_NOTE_ON
						: mnr_pkg::NIB_NOTE_OFF, ch};
					res[i].out_data_one = chord_n[i][6:0];
					res[i].out_data_two = is_on ? item.data_two : 7'd0;
				end
			end else begin
				res[0] = pass;
				vld[0] = 1'b1;
			end
		end else if (!note_ev) begin
			res[0] = pass;
			vld[0] = 1'b1;
		end else if (mode == mnr_pkg::MODE_LEGATO) begin
			if (is_on) begin
				vld[0]              = 1'b1;
				nxt_sounding        = key8;
				res[0].glide_valid  = 1'b1;
				res[0].glide_note   = item.data_one;
				if (started == mnr_pkg::NONE_NOTE) begin
					res[0]               = pass;
					res[0].glide_valid   = 1'b1;
					res[0].glide_note    = item.data_one;
					res[0].glide_instant = 1'b1;
					nxt_started          = key8;
				end
			end else if ((key8 == started) || (key8 == sounding)) begin
				vld[0] = 1'b1;
				if (sts.empty) begin
					// release carries the started note so the voice stops
					res[0]              = pass;
					res[0].out_data_one = started[6:0];
					nxt_started         = mnr_pkg::NONE_NOTE;
					nxt_sounding        = mnr_pkg::NONE_NOTE;
				end else begin
					res[0].glide_valid = 1'b1;
					res[0].glide_note  = sts.top;
					nxt_sounding       = {1'b0, sts.top};
				end
			end
		end else begin
			if (is_on) begin
				nxt_sounding = key8;
				if (sounding != mnr_pkg::NONE_NOTE) begin
					res[0].midi_valid   = 1'b1;
					res[0].out_status   = {mnr_pkg::NIB_NOTE_OFF, ch};
					res[0].out_data_one = sounding[6:0];
					res[1]              = pass;
					vld[1:0]            = 2'b11;
				end else begin
					res[0] = pass;
					vld[0] = 1'b1;
				end
			end else if (key8 == sounding) begin
				res[0] = pass;
				vld[0] = 1'b1;
				if (sts.empty) begin
					nxt_sounding = mnr_pkg::NONE_NOTE;
				end else begin
					res[1].midi_valid   = 1'b1;
					res[1].out_status   = {mnr_pkg::NIB_NOTE_ON, ch};
					res[1].out_data_one = sts.top;
					res[1].out_data_two = mnr_pkg::RETRIG_VEL;
					vld[1]              = 1'b1;
					nxt_sounding        = {1'b0, sts.top};
				end
			end
		end
	end

endmodule
